// ----- rtl/core/brcc_pkg.sv -----
// shared types and codes of the batch reservation conflict checker
`timescale 1ns / 1ps

package brcc_pkg;

  typedef enum logic [1:0] {
    ACT_RSV_WR = 2'd0,
    ACT_RSV_RD = 2'd1,
    ACT_CHK_WR = 2'd2,
    ACT_CHK_RD = 2'd3
  } brcc_action_e;

  typedef struct packed {
    logic [31:0] batch;
    logic [31:0] id;
  } brcc_entry_t;

  typedef struct packed {
    logic wr_we;
    logic rd_we;
    logic waw;
    logic raw;
    logic war;
  } brcc_upd_t;

endpackage

// ----- rtl/core/brcc_if.sv -----
// valid/ready channel interfaces for input items and verdicts
`timescale 1ns / 1ps

interface brcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] record_key;
  logic [31:0] txn_id;
  logic [31:0] batch_number;
  logic        last_check;

  modport source (
    output valid, action, record_key, txn_id, batch_number, last_check,
    input  ready
  );
  modport sink (
    input  valid, action, record_key, txn_id, batch_number, last_check,
    output ready
  );
endinterface

interface brcc_out_if;
  logic        valid;
  logic        ready;
  logic        abort_txn;
  logic        waw_seen;
  logic        raw_seen;
  logic        war_seen;
  logic [31:0] verdict_id;

  modport source (
    output valid, abort_txn, waw_seen, raw_seen, war_seen, verdict_id,
    input  ready
  );
  modport sink (
    input  valid, abort_txn, waw_seen, raw_seen, war_seen, verdict_id,
    output ready
  );
endinterface

// ----- rtl/core/batch_reservation_conflict_checker.sv -----
// top level: reservation tables, item sequencer, conflict flags and verdict register
//
//   channel  | dir | beat contents
//   in_i     | in  | action, record_key, txn_id, batch_number, last_check
//   out_o    | out | abort_txn, waw_seen, raw_seen, war_seen, verdict_id
//
// each item: table read on acceptance, then check and write-back in the execute state
// after reset a clearing pass zeroes all 2**KEY_BITS rows of both tables, one row a cycle,
// with in_i.ready low until it ends
// a verdict waits in the output register; a further verdict stalls in the write-back
// cycle until that register is taken, items without a verdict never stall
`timescale 1ns / 1ps

module batch_reservation_conflict_checker
  import brcc_pkg::*;
#(
  parameter int KEY_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brcc_in_if.sink    in_i,
  brcc_out_if.source out_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [KEY_BITS-1:0] clr_cnt_q, clr_cnt_d;

  logic [1:0]          act_q;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         id_q;
  logic [31:0]         batch_q;
  logic                last_q;

  logic waw_q, waw_d;
  logic raw_q, raw_d;
  logic war_q, war_d;

  logic        out_valid_q, out_valid_d;
  logic        out_abort_q, out_waw_q, out_raw_q, out_war_q;
  logic [31:0] out_id_q;

  logic                accept;
  logic                is_check;
  logic                needs_out;
  logic                stall;
  logic                commit;
  logic                emit;
  logic                clearing;
  logic [KEY_BITS-1:0] wr_addr;
  logic                wr_tab_we;
  logic                rd_tab_we;
  brcc_entry_t         wr_tab_rdata, rd_tab_rdata;
  brcc_entry_t         wr_new, rd_new;
  brcc_entry_t         wr_tab_wdata, rd_tab_wdata;
  brcc_upd_t           upd;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign clearing   = (state_q == ST_CLEAR);

  assign is_check  = (act_q == ACT_CHK_WR) || (act_q == ACT_CHK_RD);
  assign needs_out = is_check && last_q;
  assign stall     = needs_out && out_valid_q && !out_o.ready;
  assign commit    = (state_q == ST_EXEC) && !stall;
  assign emit      = commit && needs_out;

  brcc_table #(.KEY_BITS(KEY_BITS)) u_wr_table (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (KEY_BITS'(in_i.record_key)),
    .rd_data_o (wr_tab_rdata),
    .wr_en_i   (wr_tab_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_tab_wdata)
  );

  brcc_table #(.KEY_BITS(KEY_BITS)) u_rd_table (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (KEY_BITS'(in_i.record_key)),
    .rd_data_o (rd_tab_rdata),
    .wr_en_i   (rd_tab_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (rd_tab_wdata)
  );

  brcc_rule u_rule (
    .action_i   (act_q),
    .txn_id_i   (id_q),
    .batch_i    (batch_q),
    .wr_entry_i (wr_tab_rdata),
    .rd_entry_i (rd_tab_rdata),
    .wr_entry_o (wr_new),
    .rd_entry_o (rd_new),
    .upd_o      (upd)
  );

  // clearing pass and item write-back share the write ports
  assign wr_addr      = clearing ? clr_cnt_q : key_q;
  assign wr_tab_we    = clearing || (commit && upd.wr_we);
  assign rd_tab_we    = clearing || (commit && upd.rd_we);
  assign wr_tab_wdata = clearing ? '0 : wr_new;
  assign rd_tab_wdata = clearing ? '0 : rd_new;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + KEY_BITS'(1);
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!stall) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    waw_d = waw_q;
    raw_d = raw_q;
    war_d = war_q;
    if (commit) begin
      waw_d = waw_q | upd.waw;
      raw_d = raw_q | upd.raw;
      war_d = war_q | upd.war;
      if (needs_out) begin
        waw_d = 1'b0;
        raw_d = 1'b0;
        war_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      waw_q       <= 1'b0;
      raw_q       <= 1'b0;
      war_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      waw_q       <= waw_d;
      raw_q       <= raw_d;
      war_q       <= war_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= in_i.action;
      key_q   <= KEY_BITS'(in_i.record_key);
      id_q    <= in_i.txn_id;
      batch_q <= in_i.batch_number;
      last_q  <= in_i.last_check;
    end
  end

  // verdict includes the flags raised by the triggering beat
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_waw_q   <= waw_q | upd.waw;
      out_raw_q   <= raw_q | upd.raw;
      out_war_q   <= war_q | upd.war;
      out_abort_q <= (waw_q | upd.waw) | ((raw_q | upd.raw) & (war_q | upd.war));
      out_id_q    <= id_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.abort_txn  = out_abort_q;
  assign out_o.waw_seen   = out_waw_q;
  assign out_o.raw_seen   = out_raw_q;
  assign out_o.war_seen   = out_war_q;
  assign out_o.verdict_id = out_id_q;

  a_emit_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && (out_id_q == $past(id_q))))
    else $error("verdict not loaded into output register");

  a_emit_clears_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (!waw_q && !raw_q && !war_q))
    else $error("conflict flags not cleared after verdict");

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted beat not executed");

  a_no_out_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!out_valid_q && !waw_q && !raw_q && !war_q))
    else $error("activity during clearing pass");

endmodule

// ----- rtl/core/brcc_table.sv -----
// one reservation table: synchronous memory, one write and one registered read port
`timescale 1ns / 1ps

module brcc_table
  import brcc_pkg::*;
#(
  parameter int KEY_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [KEY_BITS-1:0] rd_addr_i,
  output brcc_entry_t         rd_data_o,
  input  logic                wr_en_i,
  input  logic [KEY_BITS-1:0] wr_addr_i,
  input  brcc_entry_t         wr_data_i
);

  localparam int Depth = 1 << KEY_BITS;

  brcc_entry_t mem_q [Depth];
  brcc_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/brcc_rule.sv -----
// reserve update and conflict check for one item against both table entries
`timescale 1ns / 1ps

module brcc_rule
  import brcc_pkg::*;
(
  input  logic [1:0]  action_i,
  input  logic [31:0] txn_id_i,
  input  logic [31:0] batch_i,
  input  brcc_entry_t wr_entry_i,
  input  brcc_entry_t rd_entry_i,
  output brcc_entry_t wr_entry_o,
  output brcc_entry_t rd_entry_o,
  output brcc_upd_t   upd_o
);

  brcc_action_e act;
  brcc_entry_t  rsv_src;
  brcc_entry_t  rsv_new;
  logic         keep;
  logic         take;
  logic         wr_older;
  logic         rd_older;

  assign act = brcc_action_e'(action_i);

  // reserve works on the table that the action names
  assign rsv_src = (act == ACT_RSV_RD) ? rd_entry_i : wr_entry_i;

  always_comb begin
    keep = (rsv_src.id != 32'd0) && (rsv_src.id <= txn_id_i) && (rsv_src.batch == batch_i);
    take = (rsv_src.id > txn_id_i) || (rsv_src.batch < batch_i) || (rsv_src.id == 32'd0);
    rsv_new = rsv_src;
    if (!keep && take) begin
      rsv_new.id = txn_id_i;
      if (rsv_src.batch < batch_i) begin
        rsv_new.batch = batch_i;
      end
    end
  end

  assign wr_older = (wr_entry_i.id != 32'd0) && (wr_entry_i.id < txn_id_i)
                    && (wr_entry_i.batch == batch_i);
  assign rd_older = (rd_entry_i.id != 32'd0) && (rd_entry_i.id < txn_id_i)
                    && (rd_entry_i.batch == batch_i);

  assign wr_entry_o = rsv_new;
  assign rd_entry_o = rsv_new;

  always_comb begin
    upd_o = '0;
    unique case (act)
      ACT_RSV_WR: upd_o.wr_we = 1'b1;
      ACT_RSV_RD: upd_o.rd_we = 1'b1;
      ACT_CHK_WR: begin
        upd_o.waw = (wr_entry_i.id != txn_id_i) || (wr_entry_i.batch != batch_i);
        upd_o.war = rd_older;
      end
      ACT_CHK_RD: upd_o.raw = wr_older;
      default:    upd_o = '0;
    endcase
  end

endmodule
